[rtl/multichannel_dac_register_port_macros.svh]
// Assertion macros for the multi-channel DAC register port.
// The including module provides clk_i and rst_ni.
`ifndef MULTICHANNEL_DAC_REGISTER_PORT_MACROS_SVH
`define MULTICHANNEL_DAC_REGISTER_PORT_MACROS_SVH

// A condition that holds at every rising clock edge outside reset.
`define MDRP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A trigger that implies a consequence in the next cycle.
`define MDRP_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/mdrp_pkg.sv]
// Types and constants for the multi-channel DAC register port.
// No dependencies.
`default_nettype none

package mdrp_pkg;

  localparam int unsigned WORD_W      = 16;
  localparam int unsigned ADDR_W      = 6;
  localparam int unsigned GROUP_OFS_W = 14;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned NUM_DIGITS  = WORD_W / DIGIT_W;
  localparam int unsigned DIG_CNT_W   = $clog2(NUM_DIGITS);

  localparam logic [DIG_CNT_W-1:0] LAST_DIGIT = DIG_CNT_W'(NUM_DIGITS - 1);

  localparam logic [ADDR_W-1:0] CHANNEL_BASE  = 6'h08;
  localparam logic [ADDR_W-1:0] SF_NOP        = 6'h00;
  localparam logic [ADDR_W-1:0] SF_CONTROL    = 6'h01;
  localparam logic [ADDR_W-1:0] SF_GROUP_BASE = 6'h02;
  localparam logic [ADDR_W-1:0] SF_GROUP_LAST = 6'h04;
  localparam logic [ADDR_W-1:0] SF_READBACK   = 6'h05;

  localparam logic [5:0] ACTIVE_RESET     = 6'd40;
  localparam logic [1:0] GROUP_SIZE_RESET = 2'd3;
  localparam logic [1:0] REF_COUNT_RESET  = 2'd2;

  typedef enum logic [1:0] {
    CMD_SPECIAL = 2'd0,
    CMD_GAIN    = 2'd1,
    CMD_OFFSET  = 2'd2,
    CMD_INPUT   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    RB_INPUT   = 3'd0,
    RB_X1B     = 3'd1,
    RB_OFFSET  = 3'd2,
    RB_GAIN    = 3'd3,
    RB_SPECIAL = 3'd4
  } rb_type_e;

  typedef enum logic [1:0] {
    CFG_ACTIVE     = 2'd0,
    CFG_GROUP_SIZE = 2'd1,
    CFG_REF_COUNT  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_EXEC,
    ST_FIN
  } state_e;

endpackage

`default_nettype wire

[rtl/multichannel_dac_register_port.sv]
// Multi-channel DAC register port: frame decoder, channel word memories, readback.
// Depends on mdrp_pkg and multichannel_dac_register_port_macros.svh.
// Items are taken one at a time (accept, four 4-bit digit shifts, decode, finish); the next
// item is accepted only after the finish step, and a stalled result holds the finish step.
// Reset clears the control word, group offsets, readback latch and channel valid bits;
// configuration returns to 40, 3 and 2.
`default_nettype none

`include "multichannel_dac_register_port_macros.svh"

module multichannel_dac_register_port #(
  parameter int unsigned MAX_CHANNELS   = 40,
  parameter int unsigned MAX_REFERENCES = 3
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [5:0]  address_i,
  input  wire logic [15:0] data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      shifted_out_word_o,
  output logic             shifted_out_valid_o,
  output logic [1:0]       reference_group_o,
  output logic             status_o,
  output logic             power_down_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [5:0]  cfg_data_i
);
  import mdrp_pkg::*;

  localparam int unsigned CH_W  = $clog2(MAX_CHANNELS);
  localparam int unsigned REF_W = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1;
  localparam logic [6:0] MAX_CH_L  = 7'(MAX_CHANNELS);
  localparam logic [1:0] MAX_REF_L = 2'(MAX_REFERENCES);

  state_e state_q, state_d;

  logic [5:0] act_q;
  logic [1:0] gsize_q;
  logic [1:0] refc_q;

  logic [WORD_W-1:0]    sh_q;
  logic [WORD_W-1:0]    asm_q;
  logic [DIG_CNT_W-1:0] dig_cnt_q;
  cmd_e                 cmd_q;
  logic [ADDR_W-1:0]    addr_q;

  logic [WORD_W-1:0] mem_in  [MAX_CHANNELS];
  logic [WORD_W-1:0] mem_ofs [MAX_CHANNELS];
  logic [WORD_W-1:0] mem_gn  [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] vld_in_q, vld_ofs_q, vld_gn_q;
  logic [WORD_W-1:0] rd_in_q, rd_ofs_q, rd_gn_q;

  logic [GROUP_OFS_W-1:0] gofs_q [MAX_REFERENCES];
  logic [WORD_W-1:0]      ctrl_q;
  logic [WORD_W-1:0]      latch_q;
  logic                   armed_q;

  rb_type_e          rb_type_q;
  logic              rb_hit_q;
  logic [WORD_W-1:0] rb_sf_q;
  logic              res_arm_q;
  logic              res_status_q;
  logic [1:0]        res_group_q;

  logic              out_valid_q;
  logic [WORD_W-1:0] out_word_q;
  logic              out_rbv_q;
  logic [1:0]        out_group_q;
  logic              out_status_q;
  logic              out_pd_q;

  logic [6:0]        eff_ch;
  logic [1:0]        eff_refs;
  logic              shift3;
  logic [ADDR_W-1:0] off;
  logic              ch_ok;
  logic [ADDR_W-1:0] rb_addr;
  logic [ADDR_W-1:0] rb_off;
  logic              rb_ch_ok;
  rb_type_e          rb_type;
  logic [ADDR_W-1:0] sfo;
  logic              sf_ok;
  logic [ADDR_W-1:0] rb_sfo;
  logic              rb_sf_ok;
  logic [ADDR_W-1:0] grp_full;
  logic [1:0]        grp;
  logic [1:0]        last_ref;
  logic              in_accept;
  logic              fin_go;
  logic              exec;
  logic              we_in, we_ofs, we_gn;
  logic              we_ctrl, we_gofs, is_rb, status;
  logic [WORD_W-1:0] rb_sf_word;
  logic              rb_hit;
  logic [WORD_W-1:0] rb_word;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= ACTIVE_RESET;
      gsize_q <= GROUP_SIZE_RESET;
      refc_q  <= REF_COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ACTIVE:     act_q   <= cfg_data_i;
        CFG_GROUP_SIZE: gsize_q <= cfg_data_i[1:0];
        CFG_REF_COUNT:  refc_q  <= cfg_data_i[1:0];
        default:        ;
      endcase
    end
  end

  // Effective configuration after clamping.
  always_comb begin
    eff_ch   = ({1'b0, act_q} > MAX_CH_L) ? MAX_CH_L : {1'b0, act_q};
    eff_refs = (refc_q == 2'd0) ? 2'd1 : refc_q;
    if (eff_refs > MAX_REF_L) begin
      eff_refs = MAX_REF_L;
    end
    shift3   = (gsize_q == 2'd3);
    last_ref = eff_refs - 2'd1;
  end

  // Frame decode.
  always_comb begin
    off      = addr_q - CHANNEL_BASE;
    ch_ok    = (addr_q >= CHANNEL_BASE) && ({1'b0, off} < eff_ch);
    rb_addr  = asm_q[12:7];
    rb_off   = rb_addr - CHANNEL_BASE;
    rb_ch_ok = (rb_addr >= CHANNEL_BASE) && ({1'b0, rb_off} < eff_ch);
    rb_type  = rb_type_e'(asm_q[15:13]);
    sfo      = addr_q - SF_GROUP_BASE;
    sf_ok    = (addr_q >= SF_GROUP_BASE) && (addr_q <= SF_GROUP_LAST) &&
               (sfo[1:0] < eff_refs);
    rb_sfo   = rb_addr - SF_GROUP_BASE;
    rb_sf_ok = (rb_addr >= SF_GROUP_BASE) && (rb_addr <= SF_GROUP_LAST) &&
               (rb_sfo[1:0] < eff_refs);

    grp_full = shift3 ? (off >> 3) : (off >> 2);
    if (addr_q < CHANNEL_BASE) begin
      grp = 2'd0;
    end else if (grp_full > {4'b0000, last_ref}) begin
      grp = last_ref;
    end else begin
      grp = grp_full[1:0];
    end

    exec    = (state_q == ST_EXEC);
    we_in   = exec && (cmd_q == CMD_INPUT) && ch_ok;
    we_ofs  = exec && (cmd_q == CMD_OFFSET) && ch_ok;
    we_gn   = exec && (cmd_q == CMD_GAIN) && ch_ok;
    we_ctrl = 1'b0;
    we_gofs = 1'b0;
    is_rb   = 1'b0;
    status  = 1'b0;
    if (cmd_q != CMD_SPECIAL) begin
      status = !ch_ok;
    end else if (addr_q == SF_NOP) begin
      status = 1'b0;
    end else if (addr_q == SF_CONTROL) begin
      we_ctrl = exec;
    end else if (addr_q == SF_READBACK) begin
      is_rb = 1'b1;
    end else begin
      status  = !sf_ok;
      we_gofs = exec && sf_ok;
    end

    if (rb_addr == SF_CONTROL) begin
      rb_sf_word = ctrl_q;
    end else if (rb_sf_ok) begin
      rb_sf_word = {{(WORD_W-GROUP_OFS_W){1'b0}}, gofs_q[rb_sfo[REF_W-1:0]]};
    end else begin
      rb_sf_word = '0;
    end

    case (rb_type)
      RB_INPUT:  rb_hit = rb_ch_ok && vld_in_q[rb_off[CH_W-1:0]];
      RB_OFFSET: rb_hit = rb_ch_ok && vld_ofs_q[rb_off[CH_W-1:0]];
      RB_GAIN:   rb_hit = rb_ch_ok && vld_gn_q[rb_off[CH_W-1:0]];
      default:   rb_hit = 1'b0;
    endcase

    case (rb_type_q)
      RB_INPUT:   rb_word = rb_hit_q ? rd_in_q : '0;
      RB_OFFSET:  rb_word = rb_hit_q ? rd_ofs_q : '0;
      RB_GAIN:    rb_word = rb_hit_q ? rd_gn_q : '0;
      RB_SPECIAL: rb_word = rb_sf_q;
      default:    rb_word = '0;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    fin_go     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (dig_cnt_q == LAST_DIGIT) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!(out_valid_q && out_stall_i)) begin
          fin_go  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_accept = in_valid_i && !in_stall_o;

  // Digit-serial transfer of the data word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_cnt_q <= '0;
    end else if (state_q == ST_SHIFT) begin
      dig_cnt_q <= dig_cnt_q + DIG_CNT_W'(1);
    end else begin
      dig_cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sh_q   <= data_i;
      cmd_q  <= cmd_e'(command_i);
      addr_q <= address_i;
    end else if (state_q == ST_SHIFT) begin
      sh_q  <= sh_q >> DIGIT_W;
      asm_q <= {sh_q[DIGIT_W-1:0], asm_q[WORD_W-1:DIGIT_W]};
    end
  end

  // Channel word memories.
  always_ff @(posedge clk_i) begin
    if (we_in) begin
      mem_in[off[CH_W-1:0]] <= asm_q;
    end
    if (exec) begin
      rd_in_q <= mem_in[rb_off[CH_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_ofs) begin
      mem_ofs[off[CH_W-1:0]] <= asm_q;
    end
    if (exec) begin
      rd_ofs_q <= mem_ofs[rb_off[CH_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_gn) begin
      mem_gn[off[CH_W-1:0]] <= asm_q;
    end
    if (exec) begin
      rd_gn_q <= mem_gn[rb_off[CH_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_in_q  <= '0;
      vld_ofs_q <= '0;
      vld_gn_q  <= '0;
    end else begin
      if (we_in) begin
        vld_in_q[off[CH_W-1:0]] <= 1'b1;
      end
      if (we_ofs) begin
        vld_ofs_q[off[CH_W-1:0]] <= 1'b1;
      end
      if (we_gn) begin
        vld_gn_q[off[CH_W-1:0]] <= 1'b1;
      end
    end
  end

  // Special registers and readback state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q  <= '0;
      latch_q <= '0;
      armed_q <= 1'b0;
      for (int i = 0; i < int'(MAX_REFERENCES); i++) begin
        gofs_q[i] <= '0;
      end
    end else begin
      if (we_ctrl) begin
        ctrl_q <= asm_q;
      end
      if (we_gofs) begin
        gofs_q[sfo[REF_W-1:0]] <= asm_q[GROUP_OFS_W-1:0];
      end
      if (fin_go) begin
        armed_q <= res_arm_q;
        if (res_arm_q) begin
          latch_q <= rb_word;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      rb_type_q    <= rb_type;
      rb_hit_q     <= rb_hit;
      rb_sf_q      <= rb_sf_word;
      res_arm_q    <= is_rb;
      res_status_q <= status;
      res_group_q  <= grp;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_word_q   <= latch_q;
      out_rbv_q    <= armed_q;
      out_group_q  <= res_group_q;
      out_status_q <= res_status_q;
      out_pd_q     <= ctrl_q[0];
    end
  end

  assign out_valid_o         = out_valid_q;
  assign shifted_out_word_o  = out_word_q;
  assign shifted_out_valid_o = out_rbv_q;
  assign reference_group_o   = out_group_q;
  assign status_o            = out_status_q;
  assign power_down_o        = out_pd_q;

  `MDRP_ASSERT_NEXT(a_accept_starts_shift, in_accept, state_q == ST_SHIFT, "accept did not start the digit shift")
  `MDRP_ASSERT_NEXT(a_last_digit_exec, (state_q == ST_SHIFT) && (dig_cnt_q == LAST_DIGIT), state_q == ST_EXEC, "shift did not end after the last digit")
  `MDRP_ASSERT_NEXT(a_fin_loads_output, fin_go, out_valid_q && (state_q == ST_IDLE), "finished item not offered")
  `MDRP_ASSERT(a_out_rise_from_fin, !$rose(out_valid_q) || $past(state_q == ST_FIN), "result appeared outside the finish step")

endmodule

`default_nettype wire

[sim/multichannel_dac_register_port_checker.sv]
// Checker for the multi-channel DAC register port: watches the item, result
// and register write channels, predicts every result from its own copy of the
// port state and compares it field by field. Depends on mdrp_pkg.
module multichannel_dac_register_port_checker #(
  parameter int unsigned MAX_CHANNELS   = 40,
  parameter int unsigned MAX_REFERENCES = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [1:0]        command_i,
  input  logic [5:0]        address_i,
  input  logic [15:0]       data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [15:0]       shifted_out_word_i,
  input  logic              shifted_out_valid_i,
  input  logic [1:0]        reference_group_i,
  input  logic              status_i,
  input  logic              power_down_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [5:0]        cfg_data_i,
  output int unsigned       pending_o,
  output int unsigned       mismatch_count_o
);
  import mdrp_pkg::*;

  localparam int unsigned PRINT_LIMIT = 100;

  typedef struct packed {
    logic [15:0] word;
    logic        word_valid;
    logic [1:0]  group;
    logic        ignored;
    logic        power_down;
  } frame_result_t;

  logic [15:0]            input_word  [MAX_CHANNELS];
  logic [15:0]            offset_word [MAX_CHANNELS];
  logic [15:0]            gain_word   [MAX_CHANNELS];
  logic [GROUP_OFS_W-1:0] group_ofs   [MAX_REFERENCES];
  logic [15:0]            control_word;
  logic [15:0]            rb_latch;
  logic                   rb_armed;
  logic [5:0]             active_cfg;
  logic [1:0]             shift_cfg;
  logic [1:0]             refs_cfg;
  frame_result_t          expected_frames[$];
  int unsigned            mismatches = 0;

  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(input string what, input logic [15:0] expected_val,
                                 input logic [15:0] actual_val);
    if (mismatches < PRINT_LIMIT) begin
      $display("%0t: %s: expected %h, got %h", $time, what, expected_val, actual_val);
    end
    mismatches++;
  endtask

  function automatic int live_channels();
    return (active_cfg > MAX_CHANNELS) ? int'(MAX_CHANNELS) : int'(active_cfg);
  endfunction

  function automatic int live_refs();
    int n;
    n = int'(refs_cfg);
    if (n < 1) n = 1;
    if (n > int'(MAX_REFERENCES)) n = int'(MAX_REFERENCES);
    return n;
  endfunction

  function automatic int group_shift();
    int s;
    s = int'(shift_cfg);
    if (s < 2) s = 2;
    if (s > 3) s = 3;
    return s;
  endfunction

  function automatic int channel_index(input logic [5:0] addr);
    if (addr < CHANNEL_BASE) return -1;
    if (int'(addr) - int'(CHANNEL_BASE) >= live_channels()) return -1;
    return int'(addr) - int'(CHANNEL_BASE);
  endfunction

  function automatic int group_slot(input logic [5:0] addr);
    if (addr < SF_GROUP_BASE || addr > SF_GROUP_LAST) return -1;
    if (int'(addr) - int'(SF_GROUP_BASE) >= live_refs()) return -1;
    return int'(addr) - int'(SF_GROUP_BASE);
  endfunction

  function automatic logic [15:0] readback_value(input logic [2:0] kind,
                                                 input logic [5:0] addr);
    int          ch;
    int          g;
    logic [15:0] word;
    ch   = channel_index(addr);
    g    = group_slot(addr);
    word = '0;
    case (kind)
      RB_INPUT:  if (ch >= 0) word = input_word[ch];
      RB_OFFSET: if (ch >= 0) word = offset_word[ch];
      RB_GAIN:   if (ch >= 0) word = gain_word[ch];
      RB_SPECIAL: begin
        if (addr == SF_CONTROL) word = control_word;
        else if (g >= 0) word = 16'(group_ofs[g]);
      end
      default: word = '0;
    endcase
    return word;
  endfunction

  function automatic frame_result_t decode_frame(input logic [1:0] cmd, input logic [5:0] addr,
                                                 input logic [15:0] data);
    frame_result_t res;
    int            ch;
    int            g;
    int            grp;
    int            last;
    logic          arm;
    res.word       = rb_latch;
    res.word_valid = rb_armed;
    res.ignored    = 1'b0;
    arm            = 1'b0;
    grp            = 0;
    if (addr >= CHANNEL_BASE) begin
      last = live_refs() - 1;
      grp  = (int'(addr) - int'(CHANNEL_BASE)) >> group_shift();
      if (grp > last) grp = last;
    end
    res.group = 2'(grp);
    if (cmd != CMD_SPECIAL) begin
      ch = channel_index(addr);
      if (ch < 0) begin
        res.ignored = 1'b1;
      end else begin
        case (cmd)
          CMD_INPUT:  input_word[ch] = data;
          CMD_OFFSET: offset_word[ch] = data;
          default:    gain_word[ch] = data;
        endcase
      end
    end else if (addr == SF_CONTROL) begin
      control_word = data;
    end else if (addr == SF_READBACK) begin
      rb_latch = readback_value(data[15:13], data[12:7]);
      arm      = 1'b1;
    end else if (addr != SF_NOP) begin
      g = group_slot(addr);
      if (g < 0) res.ignored = 1'b1;
      else group_ofs[g] = data[GROUP_OFS_W-1:0];
    end
    rb_armed       = arm;
    res.power_down = control_word[0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    frame_result_t exp_res;
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_CHANNELS); i++) begin
        input_word[i]  = '0;
        offset_word[i] = '0;
        gain_word[i]   = '0;
      end
      for (int i = 0; i < int'(MAX_REFERENCES); i++) group_ofs[i] = '0;
      control_word = '0;
      rb_latch     = '0;
      rb_armed     = 1'b0;
      active_cfg   = ACTIVE_RESET;
      shift_cfg    = GROUP_SIZE_RESET;
      refs_cfg     = REF_COUNT_RESET;
      expected_frames.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ACTIVE:     active_cfg = cfg_data_i;
          CFG_GROUP_SIZE: shift_cfg = cfg_data_i[1:0];
          CFG_REF_COUNT:  refs_cfg = cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_frames.size() == 0) begin
          report_mismatch("result with no item pending", '0, shifted_out_word_i);
        end else begin
          exp_res = expected_frames.pop_front();
          if (shifted_out_word_i !== exp_res.word)
            report_mismatch("shifted_out_word", exp_res.word, shifted_out_word_i);
          if (shifted_out_valid_i !== exp_res.word_valid)
            report_mismatch("shifted_out_valid", 16'(exp_res.word_valid),
                            16'(shifted_out_valid_i));
          if (reference_group_i !== exp_res.group)
            report_mismatch("reference_group", 16'(exp_res.group), 16'(reference_group_i));
          if (status_i !== exp_res.ignored)
            report_mismatch("status", 16'(exp_res.ignored), 16'(status_i));
          if (power_down_i !== exp_res.power_down)
            report_mismatch("power_down", 16'(exp_res.power_down), 16'(power_down_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_frames.push_back(decode_frame(command_i, address_i, data_i));
      end
      pending_o <= expected_frames.size();
    end
  end

endmodule

[sim/multichannel_dac_register_port_tb.sv]
// Testbench top for the multi-channel DAC register port: drives frames and
// register writes with random pacing and gives the verdict. Depends on mdrp_pkg,
// the block and multichannel_dac_register_port_checker.
module multichannel_dac_register_port_tb;
  import mdrp_pkg::*;

  localparam int unsigned IDLE_LIMIT      = 3000;
  localparam int unsigned LONG_HOLD       = 400;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned ITEMS_PER_PHASE = 250;
  localparam logic [2:0]  RB_UNUSED_TYPE  = 3'd7;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic [1:0]  command     = '0;
  logic [5:0]  address     = '0;
  logic [15:0] data        = '0;
  logic        out_stall   = 1'b0;
  logic        cfg_valid   = 1'b0;
  logic [1:0]  cfg_index   = '0;
  logic [5:0]  cfg_data    = '0;
  int unsigned hold_requests = 0;
  int unsigned idle_cycles   = 0;

  logic        in_stall;
  logic        out_valid;
  logic [15:0] shifted_out_word;
  logic        shifted_out_valid;
  logic [1:0]  reference_group;
  logic        status;
  logic        power_down;
  logic        cfg_ready;
  int unsigned pending;
  int unsigned mismatch_count;

  multichannel_dac_register_port DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .command_i          (command),
    .address_i          (address),
    .data_i             (data),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .shifted_out_word_o (shifted_out_word),
    .shifted_out_valid_o(shifted_out_valid),
    .reference_group_o  (reference_group),
    .status_o           (status),
    .power_down_o       (power_down),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  multichannel_dac_register_port_checker CHECKER (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .command_i          (command),
    .address_i          (address),
    .data_i             (data),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .shifted_out_word_i (shifted_out_word),
    .shifted_out_valid_i(shifted_out_valid),
    .reference_group_i  (reference_group),
    .status_i           (status),
    .power_down_i       (power_down),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .pending_o          (pending),
    .mismatch_count_o   (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    int unsigned holds_served;
    int unsigned stall_pct;
    int unsigned run_len;
    holds_served = 0;
    forever begin
      if (hold_requests != holds_served) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        holds_served++;
      end else begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
        run_len = $urandom_range(20, 200);
        repeat (run_len) begin
          out_stall <= ($urandom_range(0, 99) < stall_pct);
          @(posedge clk);
        end
      end
    end
  end

  function automatic logic [15:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] readback_request(input logic [2:0] kind,
                                                   input logic [5:0] addr);
    return {kind, addr, 7'($urandom)};
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [5:0] addr,
                           input logic [15:0] word);
    in_valid <= 1'b1;
    command  <= cmd;
    address  <= addr;
    data     <= word;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high so that writes can follow back to back.
  task automatic write_register(input cfg_idx_e idx, input logic [5:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic make_frame(output logic [1:0] cmd, output logic [5:0] addr,
                            output logic [15:0] word);
    int unsigned pick;
    logic [2:0]  kind;
    pick = $urandom_range(0, 99);
    word = random_word();
    if (pick < 35) begin
      cmd  = 2'($urandom_range(CMD_GAIN, CMD_INPUT));
      addr = CHANNEL_BASE + 6'($urandom_range(0, 39));
    end else if (pick < 55) begin
      cmd  = CMD_SPECIAL;
      addr = SF_READBACK;
      if ($urandom_range(0, 9) == 0) kind = 3'($urandom_range(RB_SPECIAL + 1, RB_UNUSED_TYPE));
      else kind = 3'($urandom_range(RB_INPUT, RB_SPECIAL));
      if (kind == RB_SPECIAL) word = readback_request(kind, 6'($urandom_range(0, 7)));
      else if ($urandom_range(0, 4) == 0) word = readback_request(kind, 6'($urandom));
      else word = readback_request(kind, CHANNEL_BASE + 6'($urandom_range(0, 39)));
    end else if (pick < 65) begin
      cmd  = CMD_SPECIAL;
      addr = SF_CONTROL;
    end else if (pick < 77) begin
      cmd  = CMD_SPECIAL;
      addr = SF_GROUP_BASE + 6'($urandom_range(0, 2));
    end else if (pick < 80) begin
      cmd  = CMD_SPECIAL;
      addr = SF_NOP;
    end else if (pick < 88) begin
      cmd  = 2'($urandom);
      addr = 6'($urandom);
    end else begin
      cmd  = 2'($urandom);
      addr = 6'($urandom);
      word = 16'($urandom);
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    logic [1:0]  cmd;
    logic [5:0]  addr;
    logic [15:0] word;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < int'(burst) && sent < count; k++) begin
        make_frame(cmd, addr, word);
        send_item(cmd, addr, word);
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic run_directed();
    send_item(CMD_SPECIAL, SF_CONTROL, 16'hffff);
    send_item(CMD_INPUT, CHANNEL_BASE, 16'hffff);
    send_item(CMD_OFFSET, 6'd47, 16'hffff);
    send_item(CMD_GAIN, 6'd47, 16'h8001);
    send_item(CMD_INPUT, 6'd48, 16'hffff);
    send_item(CMD_OFFSET, 6'd7, 16'h1234);
    send_item(CMD_GAIN, 6'd63, 16'hffff);
    send_item(CMD_SPECIAL, SF_GROUP_BASE, 16'hffff);
    send_item(CMD_SPECIAL, SF_GROUP_BASE + 6'd1, 16'hc001);
    send_item(CMD_SPECIAL, SF_GROUP_LAST, 16'h1234);
    send_item(CMD_SPECIAL, 6'd6, 16'h5555);
    send_item(CMD_SPECIAL, 6'd63, 16'haaaa);
    send_item(CMD_SPECIAL, SF_NOP, 16'hffff);
    send_item(CMD_SPECIAL, SF_READBACK, readback_request(RB_INPUT, CHANNEL_BASE));
    send_item(CMD_SPECIAL, SF_READBACK, readback_request(RB_GAIN, 6'd47));
    send_item(CMD_SPECIAL, SF_READBACK, readback_request(RB_OFFSET, 6'd47));
    send_item(CMD_SPECIAL, SF_READBACK, readback_request(RB_X1B, CHANNEL_BASE));
    send_item(CMD_SPECIAL, SF_READBACK, readback_request(RB_SPECIAL, SF_CONTROL));
    send_item(CMD_SPECIAL, SF_READBACK, readback_request(RB_SPECIAL, SF_GROUP_BASE));
    send_item(CMD_SPECIAL, SF_READBACK,
              readback_request(RB_SPECIAL, SF_GROUP_BASE + 6'd1));
    send_item(CMD_SPECIAL, SF_READBACK, readback_request(RB_SPECIAL, SF_READBACK));
    send_item(CMD_SPECIAL, SF_READBACK, readback_request(RB_SPECIAL, SF_NOP));
    send_item(CMD_SPECIAL, SF_READBACK, readback_request(RB_UNUSED_TYPE, CHANNEL_BASE));
    send_item(CMD_SPECIAL, SF_READBACK, readback_request(RB_INPUT, 6'd48));
    send_item(CMD_SPECIAL, 6'd6, readback_request(RB_INPUT, CHANNEL_BASE));
    send_item(CMD_SPECIAL, SF_CONTROL, 16'h0000);
  endtask

  initial begin : stimulus
    logic [5:0] active_val;
    logic [5:0] shift_val;
    logic [5:0] refs_val;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int phase = 0; phase < int'(NUM_PHASES); phase++) begin
      wait_for_drain();
      case (phase)
        0: begin active_val = 6'd40; shift_val = 6'd2; refs_val = 6'd3; end
        1: begin active_val = 6'd8;  shift_val = 6'd3; refs_val = 6'd1; end
        2: begin active_val = 6'd63; shift_val = 6'd0; refs_val = 6'd0; end
        3: begin active_val = 6'd0;  shift_val = 6'd3; refs_val = 6'd3; end
        default: begin
          active_val = 6'($urandom_range(8, 40));
          shift_val  = 6'($urandom_range(2, 3));
          refs_val   = 6'($urandom_range(1, 3));
        end
      endcase
      write_register(CFG_ACTIVE, active_val);
      write_register(CFG_GROUP_SIZE, shift_val);
      write_register(CFG_REF_COUNT, refs_val);
      cfg_valid <= 1'b0;
      if (phase == 1) hold_requests <= hold_requests + 1;
      run_random(ITEMS_PER_PHASE);
    end
    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
